// File: rtl/clar_pkg.sv
// shared types and constants for the compacting list
package clar_pkg;

  localparam int unsigned Capacity  = 16;
  localparam int unsigned DataWidth = 32;
  localparam int unsigned ElemWidth = 32;
  localparam int unsigned CountW    = 5;
  localparam int unsigned IdxW      = $clog2(Capacity);

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LIST   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic                 append;
    logic                 remove;
    logic                 rotate;
    logic [DataWidth-1:0] value;
  } cell_cmd_t;

endpackage

// File: rtl/compacting_list_append_remove.sv
// top level of the compacting list with append, remove and list operations
//
// usage
//   input channel: opcode_i / value_i, beat taken when in_valid_i is high
//   and in_stall_o is low. opcode append stores value_i after the last
//   held entry, remove deletes the first entry equal to value_i and packs
//   the rest down, list emits every held entry from the head
//   output channel: status_o / element_o / last_o / count_o, beat taken
//   when out_valid_o is high and out_stall_i is low
//   the result of a beat is registered and shows in the cycle after it is taken
//   append and remove are each done in parallel by the compare-and-shift
//   cells; a list run gives one beat per held entry, stepped by rotating
//   the cell row past its head, pauses while the output stalls, and
//   holds off new input until its last beat is loaded
//   the unused opcode gives no result and leaves the list alone
//   reset clears the fill count, the cell valid flags and the output
//   valid flag; entry data and the output payload are not reset
//   a stalled output holds its beat, and input is held off until the
//   output register can take the next beat
module compacting_list_append_remove (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     opcode_i,
  input  logic [31:0]                    value_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [1:0]                     status_o,
  output logic [clar_pkg::ElemWidth-1:0] element_o,
  output logic                           last_o,
  output logic [clar_pkg::CountW-1:0]    count_o
);

  // control state
  logic                         busy_q, busy_d;
  logic [clar_pkg::IdxW-1:0]    idx_q, idx_d;
  logic [clar_pkg::CountW-1:0]  count_q, count_d;
  logic                         out_valid_q, out_valid_d;

  // output payload
  clar_pkg::status_e             status_q, status_d;
  logic [clar_pkg::ElemWidth-1:0] element_q, element_d;
  logic                          last_q, last_d;
  logic [clar_pkg::CountW-1:0]   count_out_q, count_out_d;

  logic                           in_fire;
  logic                           out_ready;
  clar_pkg::op_e                  op;
  logic                           full;
  logic                           found;
  logic                           list_start;
  logic                           list_step;
  logic                           list_last;
  logic [clar_pkg::IdxW-1:0]      idx_cur;
  logic [clar_pkg::CountW-1:0]    idx_next;
  logic [clar_pkg::DataWidth-1:0] head_data;
  clar_pkg::cell_cmd_t            cmd;

  assign out_ready  = ~out_valid_q | ~out_stall_i;
  assign in_stall_o = busy_q | ~out_ready;
  assign in_fire    = in_valid_i & ~in_stall_o;
  assign op         = clar_pkg::op_e'(opcode_i);
  assign full       = (count_q == clar_pkg::CountW'(clar_pkg::Capacity));

  // a list run starts on the accepting cycle and goes on while busy
  assign list_start = in_fire & (op == clar_pkg::OP_LIST) & (count_q != '0);
  assign list_step  = list_start | (busy_q & out_ready);
  assign idx_cur    = busy_q ? idx_q : '0;
  assign idx_next   = clar_pkg::CountW'(idx_cur) + clar_pkg::CountW'(1);
  assign list_last  = (idx_next == count_q);

  assign cmd.append = in_fire & (op == clar_pkg::OP_APPEND) & ~full;
  assign cmd.remove = in_fire & (op == clar_pkg::OP_REMOVE);
  assign cmd.rotate = list_step;
  assign cmd.value  = value_i[clar_pkg::DataWidth-1:0];

  clar_chain u_chain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .found_o     (found),
    .head_data_o (head_data)
  );

  // fill count
  always_comb begin
    count_d = count_q;
    if (cmd.append) begin
      count_d = count_q + clar_pkg::CountW'(1);
    end else if (cmd.remove && found) begin
      count_d = count_q - clar_pkg::CountW'(1);
    end
  end

  // list run progress
  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (list_step) begin
      busy_d = ~list_last;
      idx_d  = idx_next[clar_pkg::IdxW-1:0];
    end
  end

  // output beat
  always_comb begin
    out_valid_d = out_valid_q & out_stall_i;
    status_d    = status_q;
    element_d   = element_q;
    last_d      = last_q;
    count_out_d = count_out_q;
    if (list_step) begin
      out_valid_d = 1'b1;
      status_d    = clar_pkg::ST_OK;
      element_d   = clar_pkg::ElemWidth'(head_data);
      last_d      = list_last;
      count_out_d = count_q;
    end else if (in_fire) begin
      element_d   = '0;
      last_d      = 1'b1;
      count_out_d = count_d;
      case (op)
        clar_pkg::OP_APPEND: begin
          out_valid_d = 1'b1;
          status_d    = full ? clar_pkg::ST_FULL : clar_pkg::ST_OK;
        end
        clar_pkg::OP_REMOVE: begin
          out_valid_d = 1'b1;
          status_d    = found ? clar_pkg::ST_OK : clar_pkg::ST_NOT_FOUND;
        end
        clar_pkg::OP_LIST: begin
          // only reached with nothing held
          out_valid_d = 1'b1;
          status_d    = clar_pkg::ST_EMPTY;
        end
        default: begin
          // unused opcode: no beat
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      idx_q       <= idx_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q    <= status_d;
    element_q   <= element_d;
    last_q      <= last_d;
    count_out_q <= count_out_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign element_o   = element_q;
  assign last_o      = last_q;
  assign count_o     = count_out_q;

endmodule

// File: rtl/clar_cell.sv
// one list cell: holds an entry, compares it and takes its neighbour's entry on a shift
module clar_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  clar_pkg::cell_cmd_t           cmd_i,
  input  logic                          hit_i,
  input  logic                          prev_valid_i,
  input  logic                          next_valid_i,
  input  logic [clar_pkg::DataWidth-1:0] next_data_i,
  input  logic [clar_pkg::DataWidth-1:0] head_data_i,
  output logic                          hit_o,
  output logic                          valid_o,
  output logic [clar_pkg::DataWidth-1:0] data_o
);

  logic                           valid_q, valid_d;
  logic [clar_pkg::DataWidth-1:0] data_q, data_d;
  logic                           match;
  logic                           shift;
  logic                           append_here;

  assign match       = valid_q & (data_q == cmd_i.value);
  assign shift       = hit_i | match;
  assign append_here = ~valid_q & prev_valid_i;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (cmd_i.append && append_here) begin
      valid_d = 1'b1;
      data_d  = cmd_i.value;
    end else if (cmd_i.remove && shift) begin
      // close the gap left by the first match
      valid_d = next_valid_i;
      data_d  = next_data_i;
    end else if (cmd_i.rotate) begin
      // last held cell wraps round to the head entry
      data_d = (valid_q && !next_valid_i) ? head_data_i : next_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign hit_o   = shift;
  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: rtl/clar_chain.sv
// row of list cells linked to their neighbours
module clar_chain (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  clar_pkg::cell_cmd_t            cmd_i,
  output logic                           found_o,
  output logic [clar_pkg::DataWidth-1:0] head_data_o
);

  logic [clar_pkg::Capacity:0]   hit;
  logic [clar_pkg::Capacity:0]   valid;
  logic [clar_pkg::DataWidth-1:0] data [clar_pkg::Capacity+1];

  assign hit[0]                   = 1'b0;
  assign valid[clar_pkg::Capacity] = 1'b0;
  assign data[clar_pkg::Capacity]  = '0;

  for (genvar i = 0; i < clar_pkg::Capacity; i++) begin : g_cell
    logic prev_valid;
    if (i == 0) begin : g_first
      assign prev_valid = 1'b1;
    end else begin : g_rest
      assign prev_valid = valid[i-1];
    end

    clar_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd_i),
      .hit_i        (hit[i]),
      .prev_valid_i (prev_valid),
      .next_valid_i (valid[i+1]),
      .next_data_i  (data[i+1]),
      .head_data_i  (data[0]),
      .hit_o        (hit[i+1]),
      .valid_o      (valid[i]),
      .data_o       (data[i])
    );
  end

  assign found_o     = hit[clar_pkg::Capacity];
  assign head_data_o = data[0];

endmodule

// File: rtl/clar_checker.sv
// port-level checks for the compacting list, bound to the top level
module clar_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [1:0]                     status_o,
  input logic [clar_pkg::ElemWidth-1:0] element_o,
  input logic                           last_o,
  input logic [clar_pkg::CountW-1:0]    count_o
);

  // a beat waiting on a stall stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output beat withdrawn while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> count_o <= clar_pkg::CountW'(clar_pkg::Capacity))
    else $error("count above capacity");

  // only list beats carry an element, and every status other than ST_OK ends its item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != clar_pkg::ST_OK |-> last_o && element_o == '0)
    else $error("error status beat not final or carries an element");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == clar_pkg::ST_EMPTY |-> count_o == '0)
    else $error("empty list reported with entries held");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == clar_pkg::ST_FULL
      |-> count_o == clar_pkg::CountW'(clar_pkg::Capacity))
    else $error("full reported below capacity");

endmodule

bind compacting_list_append_remove clar_checker u_clar_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .status_o    (status_o),
  .element_o   (element_o),
  .last_o      (last_o),
  .count_o     (count_o)
);
